// File: rtl/camera_ray_generator_defines.svh
// ---------------------------------------------------------------------------
// camera ray generator assertion macros
// shared concurrent check forms, clocked on clk and held off during reset
// ---------------------------------------------------------------------------
`ifndef CAMERA_RAY_GENERATOR_DEFINES_SVH
`define CAMERA_RAY_GENERATOR_DEFINES_SVH

// same-cycle implication
`define CRG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("camera_ray_generator: same-cycle check failed");

// next-cycle implication
`define CRG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("camera_ray_generator: next-cycle check failed");

`endif

// File: rtl/crg_pkg.sv
// ---------------------------------------------------------------------------
// crg_pkg
// widths, register codes and beat types of the camera ray generator
// ---------------------------------------------------------------------------
`default_nettype none

package crg_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int REG_W      = 60;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_IDX_LSB = 3;

    localparam int PIX_W   = 12;
    localparam int COORD_W = 20;
    localparam int GRID_W  = 30;
    localparam int DIR_W   = 16;
    localparam int DELTA_W = 21;
    localparam int SQ_W    = 42;
    localparam int SUM_W   = 44;
    localparam int RAD_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int REM_W   = 36;
    localparam int NUM_W   = 46;
    localparam int QUO_W   = 15;

    localparam int COORD_MAX = 524287;
    localparam int COORD_MIN = -524288;
    localparam int GRID_MAX  = 536870911;
    localparam int GRID_MIN  = -536870912;
    localparam int UNIT_ONE  = 16384;

    typedef enum logic [2:0] {
        REG_NEAR_CENTER,
        REG_FAR_CENTER,
        REG_SIDE_AXIS,
        REG_UP_AXIS,
        REG_NEAR_X_GRID,
        REG_NEAR_Y_GRID,
        REG_FAR_X_GRID,
        REG_FAR_Y_GRID
    } reg_idx_t;

    typedef struct packed {
        logic [REG_W-1:0] near_center;
        logic [REG_W-1:0] far_center;
        logic [REG_W-1:0] side_axis;
        logic [REG_W-1:0] up_axis;
        logic [REG_W-1:0] near_x_grid;
        logic [REG_W-1:0] near_y_grid;
        logic [REG_W-1:0] far_x_grid;
        logic [REG_W-1:0] far_y_grid;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_col;
        logic [PIX_W-1:0] pixel_row;
    } pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0]          col;
        logic [PIX_W-1:0]          row;
        logic [2:0][COORD_W-1:0]   s;
        logic [2:0][COORD_W-1:0]   e;
    } point_t;

    typedef struct packed {
        logic [PIX_W-1:0]          col;
        logic [PIX_W-1:0]          row;
        logic [2:0][COORD_W-1:0]   s;
        logic [2:0][DELTA_W-1:0]   d;
        logic [ROOT_W-1:0]         len;
        logic                      degen;
    } len_t;

    typedef struct packed {
        logic [PIX_W-1:0]          ray_col;
        logic [PIX_W-1:0]          ray_row;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic signed [DIR_W-1:0]   dir_z;
        logic                      degenerate;
    } ray_t;

endpackage

`default_nettype wire

// File: rtl/crg_stream_if.sv
// ---------------------------------------------------------------------------
// crg_stream_if
// valid/ready channel carrying one beat of payload type T
// ---------------------------------------------------------------------------
`default_nettype none

interface crg_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/crg_point.sv
// ---------------------------------------------------------------------------
// crg_point
// three stages: grid coordinates, axis products, rounded saturated points
// ---------------------------------------------------------------------------
`default_nettype none

module crg_point #(
    parameter int MAX_WIDTH  = crg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = crg_pkg::MAX_HEIGHT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  crg_pkg::cfg_t cfg,
    crg_stream_if.sink    pix,
    crg_stream_if.source  pt
);

    localparam int NS    = 3;
    localparam int GS_W  = crg_pkg::GRID_W + crg_pkg::PIX_W + 2;
    localparam int PR_W  = crg_pkg::GRID_W + crg_pkg::COORD_W;
    localparam int ACC_W = PR_W + 2;
    localparam int FRAC  = 16;
    localparam int RND_W = ACC_W - FRAC;

    function automatic logic signed [crg_pkg::COORD_W-1:0] comp(
        input logic [crg_pkg::REG_W-1:0] r,
        input int                        k
    );
        return $signed(r[crg_pkg::COORD_W*k +: crg_pkg::COORD_W]);
    endfunction

    function automatic logic signed [crg_pkg::GRID_W-1:0] grid_coord(
        input logic [crg_pkg::REG_W-1:0] r,
        input logic [crg_pkg::PIX_W-1:0] idx
    );
        logic signed [crg_pkg::GRID_W-1:0] start;
        logic signed [crg_pkg::GRID_W-1:0] step;
        logic signed [GS_W-2:0]            prod;
        logic signed [GS_W-1:0]            sum;
        start = $signed(r[crg_pkg::GRID_W-1:0]);
        step  = $signed(r[2*crg_pkg::GRID_W-1:crg_pkg::GRID_W]);
        prod  = step * $signed({1'b0, idx});
        sum   = GS_W'(prod) + GS_W'(start);
        if (sum > GS_W'(crg_pkg::GRID_MAX))
            return crg_pkg::GRID_W'(crg_pkg::GRID_MAX);
        if (sum < GS_W'(crg_pkg::GRID_MIN))
            return crg_pkg::GRID_W'(crg_pkg::GRID_MIN);
        return sum[crg_pkg::GRID_W-1:0];
    endfunction

    function automatic logic [crg_pkg::COORD_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [RND_W-1:0] f;
        f = $signed(v[ACC_W-1:FRAC]);
        if (f > RND_W'(crg_pkg::COORD_MAX))
            return crg_pkg::COORD_W'(crg_pkg::COORD_MAX);
        if (f < RND_W'(crg_pkg::COORD_MIN))
            return crg_pkg::COORD_W'(crg_pkg::COORD_MIN);
        return f[crg_pkg::COORD_W-1:0];
    endfunction

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    logic [crg_pkg::PIX_W-1:0]         col_c;
    logic [crg_pkg::PIX_W-1:0]         row_c;
    logic [crg_pkg::PIX_W-1:0]         col0_reg;
    logic [crg_pkg::PIX_W-1:0]         row0_reg;
    logic [crg_pkg::PIX_W-1:0]         col1_reg;
    logic [crg_pkg::PIX_W-1:0]         row1_reg;
    logic signed [crg_pkg::GRID_W-1:0] grid_next [4];
    logic signed [crg_pkg::GRID_W-1:0] grid0_reg [4];
    logic signed [PR_W-1:0]            prod_next [12];
    logic signed [PR_W-1:0]            prod1_reg [12];
    crg_pkg::point_t                   pt_next;
    crg_pkg::point_t                   pt_reg;

    assign en[NS] = pt.ready;
    for (genvar k = 0; k < NS; k++)
    begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end

    assign pix.ready = en[0];
    assign pt.valid  = v_reg[NS-1];
    assign pt.data   = pt_reg;

    always_comb
    begin
        col_c = pix.data.pixel_col;
        row_c = pix.data.pixel_row;
        if (int'(col_c) >= MAX_WIDTH)
            col_c = crg_pkg::PIX_W'(MAX_WIDTH - 1);
        if (int'(row_c) >= MAX_HEIGHT)
            row_c = crg_pkg::PIX_W'(MAX_HEIGHT - 1);

        grid_next[0] = grid_coord(cfg.near_x_grid, col_c);
        grid_next[1] = grid_coord(cfg.near_y_grid, row_c);
        grid_next[2] = grid_coord(cfg.far_x_grid, col_c);
        grid_next[3] = grid_coord(cfg.far_y_grid, row_c);

        pt_next.col = col1_reg;
        pt_next.row = row1_reg;
        for (int k = 0; k < 3; k++)
        begin
            prod_next[k]   = grid0_reg[0] * comp(cfg.side_axis, k);
            prod_next[3+k] = grid0_reg[1] * comp(cfg.up_axis, k);
            prod_next[6+k] = grid0_reg[2] * comp(cfg.side_axis, k);
            prod_next[9+k] = grid0_reg[3] * comp(cfg.up_axis, k);
            pt_next.s[k] = round_sat((ACC_W'(comp(cfg.near_center, k)) <<< FRAC)
                + ACC_W'(prod1_reg[k]) + ACC_W'(prod1_reg[3+k])
                + ACC_W'(32768));
            pt_next.e[k] = round_sat((ACC_W'(comp(cfg.far_center, k)) <<< FRAC)
                + ACC_W'(prod1_reg[6+k]) + ACC_W'(prod1_reg[9+k])
                + ACC_W'(32768));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= pix.valid;
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            col0_reg  <= col_c;
            row0_reg  <= row_c;
            grid0_reg <= grid_next;
        end
        if (en[1])
        begin
            col1_reg  <= col0_reg;
            row1_reg  <= row0_reg;
            prod1_reg <= prod_next;
        end
        if (en[2])
            pt_reg <= pt_next;
    end

endmodule

`default_nettype wire

// File: rtl/crg_sqrt.sv
// ---------------------------------------------------------------------------
// crg_sqrt
// direction squares, squared length, then one root bit per stage
// ---------------------------------------------------------------------------
`default_nettype none

module crg_sqrt (
    input  logic         clk,
    input  logic         rst_n,
    crg_stream_if.sink   pt,
    crg_stream_if.source ln
);

    localparam int NS = 2 + crg_pkg::ROOT_W;

    typedef struct packed {
        logic [crg_pkg::PIX_W-1:0]           col;
        logic [crg_pkg::PIX_W-1:0]           row;
        logic [2:0][crg_pkg::COORD_W-1:0]    s;
        logic [2:0][crg_pkg::DELTA_W-1:0]    d;
        logic [2:0][crg_pkg::SQ_W-1:0]       sq;
        logic [crg_pkg::RAD_W-1:0]           rad;
        logic [crg_pkg::REM_W-1:0]           rem;
        logic [crg_pkg::ROOT_W-1:0]          root;
        logic                                degen;
    } sq_stage_t;

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;
    sq_stage_t     st_reg  [NS];
    sq_stage_t     st_next [NS];

    assign en[NS] = ln.ready;
    for (genvar k = 0; k < NS; k++)
    begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end

    assign pt.ready       = en[0];
    assign ln.valid       = v_reg[NS-1];
    assign ln.data.col    = st_reg[NS-1].col;
    assign ln.data.row    = st_reg[NS-1].row;
    assign ln.data.s      = st_reg[NS-1].s;
    assign ln.data.d      = st_reg[NS-1].d;
    assign ln.data.len    = st_reg[NS-1].root;
    assign ln.data.degen  = st_reg[NS-1].degen;

    always_comb
    begin
        logic signed [crg_pkg::DELTA_W-1:0] dt;
        logic signed [crg_pkg::SQ_W-1:0]    sqt;
        logic [crg_pkg::SUM_W-1:0]          sum;
        logic [crg_pkg::REM_W-1:0]          rin;
        logic [crg_pkg::REM_W-1:0]          trial;

        st_next[0]      = '0;
        st_next[0].col  = pt.data.col;
        st_next[0].row  = pt.data.row;
        st_next[0].s    = pt.data.s;
        for (int k = 0; k < 3; k++)
        begin
            dt  = crg_pkg::DELTA_W'($signed(pt.data.e[k]))
                - crg_pkg::DELTA_W'($signed(pt.data.s[k]));
            sqt = dt * dt;
            st_next[0].d[k]  = dt;
            st_next[0].sq[k] = sqt;
        end

        st_next[1] = st_reg[0];
        sum = crg_pkg::SUM_W'(st_reg[0].sq[0]) + crg_pkg::SUM_W'(st_reg[0].sq[1])
            + crg_pkg::SUM_W'(st_reg[0].sq[2]);
        st_next[1].rad   = {sum, (crg_pkg::RAD_W - crg_pkg::SUM_W)'(0)};
        st_next[1].degen = (sum == '0);
        st_next[1].rem   = '0;
        st_next[1].root  = '0;

        for (int j = 2; j < NS; j++)
        begin
            st_next[j] = st_reg[j-1];
            rin   = {st_reg[j-1].rem[crg_pkg::REM_W-3:0],
                     st_reg[j-1].rad[crg_pkg::RAD_W-1:crg_pkg::RAD_W-2]};
            trial = {2'b00, st_reg[j-1].root, 2'b01};
            st_next[j].rad = st_reg[j-1].rad << 2;
            if (rin >= trial)
            begin
                st_next[j].rem  = rin - trial;
                st_next[j].root = {st_reg[j-1].root[crg_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                st_next[j].rem  = rin;
                st_next[j].root = {st_reg[j-1].root[crg_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= pt.valid;
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (en[k])
                st_reg[k] <= st_next[k];
        end
    end

endmodule

`default_nettype wire

// File: rtl/crg_div.sv
// ---------------------------------------------------------------------------
// crg_div
// rounded per-component divide by the length, one quotient bit per stage,
// then clamp, sign and the output register
// ---------------------------------------------------------------------------
`default_nettype none

module crg_div (
    input  logic         clk,
    input  logic         rst_n,
    crg_stream_if.sink   ln,
    crg_stream_if.source ray
);

    localparam int ND = 1 + crg_pkg::QUO_W;
    localparam int NS = ND + 1;

    typedef struct packed {
        logic [crg_pkg::PIX_W-1:0]         col;
        logic [crg_pkg::PIX_W-1:0]         row;
        logic [2:0][crg_pkg::COORD_W-1:0]  s;
        logic [2:0][crg_pkg::DELTA_W-1:0]  d;
        logic [crg_pkg::ROOT_W-1:0]        len;
        logic                              degen;
        logic [2:0][crg_pkg::NUM_W-1:0]    rem;
        logic [2:0][crg_pkg::QUO_W-1:0]    quo;
    } dv_stage_t;

    logic [NS-1:0]  v_reg;
    logic [NS:0]    en;
    dv_stage_t      st_reg  [ND];
    dv_stage_t      st_next [ND];
    crg_pkg::ray_t  ray_reg;
    crg_pkg::ray_t  ray_next;

    assign en[NS] = ray.ready;
    for (genvar k = 0; k < NS; k++)
    begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end

    assign ln.ready  = en[0];
    assign ray.valid = v_reg[NS-1];
    assign ray.data  = ray_reg;

    always_comb
    begin
        logic [crg_pkg::DELTA_W-1:0]      mag;
        logic [crg_pkg::NUM_W-1:0]        den;
        logic [crg_pkg::QUO_W-1:0]        r;
        logic signed [crg_pkg::DIR_W-1:0] q [3];
        dv_stage_t                        last;

        st_next[0]       = '0;
        st_next[0].col   = ln.data.col;
        st_next[0].row   = ln.data.row;
        st_next[0].s     = ln.data.s;
        st_next[0].d     = ln.data.d;
        st_next[0].len   = ln.data.len;
        st_next[0].degen = ln.data.degen;
        for (int k = 0; k < 3; k++)
        begin
            mag = ln.data.d[k][crg_pkg::DELTA_W-1] ? -ln.data.d[k] : ln.data.d[k];
            st_next[0].rem[k] = (crg_pkg::NUM_W'(mag) << 24)
                + crg_pkg::NUM_W'(ln.data.len >> 1);
        end

        for (int j = 1; j < ND; j++)
        begin
            st_next[j] = st_reg[j-1];
            den = crg_pkg::NUM_W'(st_reg[j-1].len) << (ND - 1 - j);
            for (int k = 0; k < 3; k++)
            begin
                if (st_reg[j-1].rem[k] >= den)
                begin
                    st_next[j].rem[k] = st_reg[j-1].rem[k] - den;
                    st_next[j].quo[k][ND-1-j] = 1'b1;
                end
            end
        end

        last = st_reg[ND-1];
        for (int k = 0; k < 3; k++)
        begin
            r = last.quo[k];
            if (r > crg_pkg::QUO_W'(crg_pkg::UNIT_ONE))
                r = crg_pkg::QUO_W'(crg_pkg::UNIT_ONE);
            if (last.degen)
                q[k] = '0;
            else if (last.d[k][crg_pkg::DELTA_W-1])
                q[k] = -$signed({1'b0, r});
            else
                q[k] = $signed({1'b0, r});
        end

        ray_next.ray_col    = last.col;
        ray_next.ray_row    = last.row;
        ray_next.start_x    = $signed(last.s[0]);
        ray_next.start_y    = $signed(last.s[1]);
        ray_next.start_z    = $signed(last.s[2]);
        ray_next.dir_x      = q[0];
        ray_next.dir_y      = q[1];
        ray_next.dir_z      = q[2];
        ray_next.degenerate = last.degen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= ln.valid;
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ND; k++)
        begin
            if (en[k])
                st_reg[k] <= st_next[k];
        end
        if (en[NS-1])
            ray_reg <= ray_next;
    end

endmodule

`default_nettype wire

// File: rtl/camera_ray_generator.sv
// ---------------------------------------------------------------------------
// camera_ray_generator
// one primary ray (start point and unit direction) per pixel beat
// ---------------------------------------------------------------------------
// usage:
//   software writes the eight 60-bit camera registers over the apb port
//   (register i at byte address 8*i, 64-bit data) while no ray is in flight
//   pixel beats (column, row) enter on the pixel channel, ray beats leave
//   on the ray channel in the same order, one ray per pixel
//   pipeline: 54 register stages: the three point stages, two length stages,
//   32 square-root bit stages and sixteen divide stages plus the output register
//   throughput: one pixel per cycle unless a held ray beat has filled the
//   pipe; every stage has its own valid bit and a stage moves on whenever
//   the stage after it is empty or moving
//   stall: a held ray beat stalls only the stages behind it up to the first
//   empty one, so pixels keep entering until the pipe is full
//   reset: clears all valid bits and the camera registers to zero
// ---------------------------------------------------------------------------
`default_nettype none

`include "camera_ray_generator_defines.svh"

module camera_ray_generator #(
    parameter int MAX_WIDTH  = crg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = crg_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [crg_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [crg_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [crg_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    crg_stream_if.sink                       pixel,
    crg_stream_if.source                     ray
);

    crg_pkg::cfg_t     cfg_reg;
    crg_pkg::reg_idx_t idx;
    logic              wr_en;
    logic [crg_pkg::REG_W-1:0] rd_val;

    crg_stream_if #(.T(crg_pkg::point_t)) pt_ch ();
    crg_stream_if #(.T(crg_pkg::len_t))   ln_ch ();

    assign pready = 1'b1;
    assign idx    = crg_pkg::reg_idx_t'(paddr[crg_pkg::CFG_ADDR_W-1:crg_pkg::CFG_IDX_LSB]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                crg_pkg::REG_NEAR_CENTER: cfg_reg.near_center <= pwdata[crg_pkg::REG_W-1:0];
                crg_pkg::REG_FAR_CENTER:  cfg_reg.far_center  <= pwdata[crg_pkg::REG_W-1:0];
                crg_pkg::REG_SIDE_AXIS:   cfg_reg.side_axis   <= pwdata[crg_pkg::REG_W-1:0];
                crg_pkg::REG_UP_AXIS:     cfg_reg.up_axis     <= pwdata[crg_pkg::REG_W-1:0];
                crg_pkg::REG_NEAR_X_GRID: cfg_reg.near_x_grid <= pwdata[crg_pkg::REG_W-1:0];
                crg_pkg::REG_NEAR_Y_GRID: cfg_reg.near_y_grid <= pwdata[crg_pkg::REG_W-1:0];
                crg_pkg::REG_FAR_X_GRID:  cfg_reg.far_x_grid  <= pwdata[crg_pkg::REG_W-1:0];
                crg_pkg::REG_FAR_Y_GRID:  cfg_reg.far_y_grid  <= pwdata[crg_pkg::REG_W-1:0];
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            crg_pkg::REG_NEAR_CENTER: rd_val = cfg_reg.near_center;
            crg_pkg::REG_FAR_CENTER:  rd_val = cfg_reg.far_center;
            crg_pkg::REG_SIDE_AXIS:   rd_val = cfg_reg.side_axis;
            crg_pkg::REG_UP_AXIS:     rd_val = cfg_reg.up_axis;
            crg_pkg::REG_NEAR_X_GRID: rd_val = cfg_reg.near_x_grid;
            crg_pkg::REG_NEAR_Y_GRID: rd_val = cfg_reg.near_y_grid;
            crg_pkg::REG_FAR_X_GRID:  rd_val = cfg_reg.far_x_grid;
            crg_pkg::REG_FAR_Y_GRID:  rd_val = cfg_reg.far_y_grid;
            default:                  rd_val = '0;
        endcase
        prdata = crg_pkg::CFG_DATA_W'(rd_val);
    end

    crg_point #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_point (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .pix   (pixel),
        .pt    (pt_ch.source)
    );

    crg_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .pt    (pt_ch.sink),
        .ln    (ln_ch.source)
    );

    crg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ln    (ln_ch.sink),
        .ray   (ray)
    );

    // zero-length rays carry a zero direction
    `CRG_ASSERT_SAME(a_degen_zero_dir, ray.valid && ray.data.degenerate, ray.data.dir_x == 16'sd0 && ray.data.dir_y == 16'sd0 && ray.data.dir_z == 16'sd0)

    // direction components never leave the unit range
    `CRG_ASSERT_SAME(a_dir_range, ray.valid, ray.data.dir_x <= 16'sd16384 && ray.data.dir_x >= -16'sd16384 && ray.data.dir_y <= 16'sd16384 && ray.data.dir_y >= -16'sd16384 && ray.data.dir_z <= 16'sd16384 && ray.data.dir_z >= -16'sd16384)

    // a write to the near plane center lands in the register
    `CRG_ASSERT_NEXT(a_cfg_write, wr_en && idx == crg_pkg::REG_NEAR_CENTER, cfg_reg.near_center == $past(pwdata[crg_pkg::REG_W-1:0]))

endmodule

`default_nettype wire
